>>> sv/pic_core_instruction_execute_macros.svh
// ----------------------------------------------------------------------------
// PIC execute unit assertion macros
// Shared helpers for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PIC_CORE_INSTRUCTION_EXECUTE_MACROS_SVH
`define PIC_CORE_INSTRUCTION_EXECUTE_MACROS_SVH

// Same-cycle implication, checked while out of reset
`define PICE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pice: same-cycle check failed");

// Next-cycle implication, checked while out of reset
`define PICE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pice: next-cycle check failed");

`endif

>>> sv/pice_pkg.sv
// ----------------------------------------------------------------------------
// PIC execute unit package
// Operation codes, masks, register map and the structs passed between units.
// ----------------------------------------------------------------------------
package pice_pkg;

    // Return stack depth default
    localparam int STACK_DEPTH = 8;

    // Field widths
    localparam int OP_W   = 6;
    localparam int BYTE_W = 8;
    localparam int BIT_W  = 3;
    localparam int TGT_W  = 11;
    localparam int PC_W   = 13;
    localparam int ACT_W  = 2;

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [0:0] REG_CORE_KIND = 1'b0;

    // Core kinds
    localparam logic CORE_BASELINE = 1'b0;
    localparam logic CORE_MIDRANGE = 1'b1;

    // Branch target masks
    localparam logic [TGT_W-1:0] CALL_MASK_BASE = 11'h0ff;
    localparam logic [TGT_W-1:0] GOTO_MASK_BASE = 11'h1ff;
    localparam logic [TGT_W-1:0] JUMP_MASK_MID  = 11'h7ff;

    // Next-PC actions
    localparam logic [ACT_W-1:0] PC_INC   = 2'd0;
    localparam logic [ACT_W-1:0] PC_SKIP  = 2'd1;
    localparam logic [ACT_W-1:0] PC_JUMP  = 2'd2;
    localparam logic [ACT_W-1:0] PC_SLEEP = 2'd3;

    // Instruction kinds
    localparam logic [OP_W-1:0] OP_ADDWF  = 6'd0;
    localparam logic [OP_W-1:0] OP_ANDLW  = 6'd1;
    localparam logic [OP_W-1:0] OP_ANDWF  = 6'd2;
    localparam logic [OP_W-1:0] OP_BCF    = 6'd3;
    localparam logic [OP_W-1:0] OP_BSF    = 6'd4;
    localparam logic [OP_W-1:0] OP_BTFSC  = 6'd5;
    localparam logic [OP_W-1:0] OP_BTFSS  = 6'd6;
    localparam logic [OP_W-1:0] OP_CALL   = 6'd7;
    localparam logic [OP_W-1:0] OP_CLRF   = 6'd8;
    localparam logic [OP_W-1:0] OP_CLRW   = 6'd9;
    localparam logic [OP_W-1:0] OP_CLRWDT = 6'd10;
    localparam logic [OP_W-1:0] OP_COMF   = 6'd11;
    localparam logic [OP_W-1:0] OP_DECF   = 6'd12;
    localparam logic [OP_W-1:0] OP_DECFSZ = 6'd13;
    localparam logic [OP_W-1:0] OP_GOTO   = 6'd14;
    localparam logic [OP_W-1:0] OP_INCF   = 6'd15;
    localparam logic [OP_W-1:0] OP_INCFSZ = 6'd16;
    localparam logic [OP_W-1:0] OP_IORLW  = 6'd17;
    localparam logic [OP_W-1:0] OP_IORWF  = 6'd18;
    localparam logic [OP_W-1:0] OP_MOVLW  = 6'd19;
    localparam logic [OP_W-1:0] OP_MOVF   = 6'd20;
    localparam logic [OP_W-1:0] OP_MOVWF  = 6'd21;
    localparam logic [OP_W-1:0] OP_NOP    = 6'd22;
    localparam logic [OP_W-1:0] OP_OPTION = 6'd23;
    localparam logic [OP_W-1:0] OP_RETLW  = 6'd24;
    localparam logic [OP_W-1:0] OP_RLF    = 6'd25;
    localparam logic [OP_W-1:0] OP_RRF    = 6'd26;
    localparam logic [OP_W-1:0] OP_SLEEP  = 6'd27;
    localparam logic [OP_W-1:0] OP_SUBWF  = 6'd28;
    localparam logic [OP_W-1:0] OP_SWAPF  = 6'd29;
    localparam logic [OP_W-1:0] OP_TRIS   = 6'd30;
    localparam logic [OP_W-1:0] OP_XORLW  = 6'd31;
    localparam logic [OP_W-1:0] OP_XORWF  = 6'd32;

    // One decoded instruction
    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [BYTE_W-1:0] file_value;
        logic [BYTE_W-1:0] literal;
        logic              to_file;
        logic [BIT_W-1:0]  bit_index;
        logic [TGT_W-1:0]  branch_target;
        logic [PC_W-1:0]   next_address;
        logic [PC_W-1:0]   page_bits;
    } instr_t;

    // W and status flags
    typedef struct packed {
        logic [BYTE_W-1:0] w;
        logic              c;
        logic              dc;
        logic              z;
    } arch_t;

    // Return stack request
    typedef struct packed {
        logic            push;
        logic            pop;
        logic [PC_W-1:0] push_addr;
    } stack_ctl_t;

    // One result item
    typedef struct packed {
        logic              write_file;
        logic [BYTE_W-1:0] result_value;
        logic [BYTE_W-1:0] w_value;
        logic              carry_flag;
        logic              digit_carry_flag;
        logic              zero_flag;
        logic [ACT_W-1:0]  pc_action;
        logic [PC_W-1:0]   next_pc;
        logic              clear_watchdog;
        logic              option_write;
        logic              tris_write;
    } result_t;

endpackage

>>> sv/pice_stack.sv
// ----------------------------------------------------------------------------
// PIC return stack
// Circular return stack with per-entry valid bits; unwritten entries read zero.
// ----------------------------------------------------------------------------
module pice_stack #(
    parameter int STACK_DEPTH = pice_pkg::STACK_DEPTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  pice_pkg::stack_ctl_t        ctl,
    output logic [pice_pkg::PC_W-1:0]   top_data
);

    localparam int PTR_W = $clog2(STACK_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(STACK_DEPTH - 1);

    logic [pice_pkg::PC_W-1:0] entry_mem [STACK_DEPTH];
    logic [STACK_DEPTH-1:0]    valid_reg;
    logic [STACK_DEPTH-1:0]    valid_next;
    logic [PTR_W-1:0]          sp_reg;
    logic [PTR_W-1:0]          sp_next;
    logic [PTR_W-1:0]          sp_prev;
    logic [PTR_W-1:0]          sp_inc;

    // Wrap the pointer at both ends
    assign sp_prev = (sp_reg == '0) ? PTR_LAST : sp_reg - PTR_W'(1);
    assign sp_inc  = (sp_reg == PTR_LAST) ? '0 : sp_reg + PTR_W'(1);

    // Most recent entry, zero until written
    assign top_data = valid_reg[sp_prev] ? entry_mem[sp_prev] : '0;

    always_comb begin
        sp_next    = sp_reg;
        valid_next = valid_reg;
        if (ctl.push) begin
            sp_next            = sp_inc;
            valid_next[sp_reg] = 1'b1;
        end else if (ctl.pop) begin
            sp_next = sp_prev;
        end
    end

    // Pointer and valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg    <= '0;
            valid_reg <= '0;
        end else begin
            sp_reg    <= sp_next;
            valid_reg <= valid_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (ctl.push) begin
            entry_mem[sp_reg] <= ctl.push_addr;
        end
    end

endmodule

>>> sv/pice_alu.sv
// ----------------------------------------------------------------------------
// PIC execute ALU
// Combinational instruction evaluation: write-back byte, W, flags, PC action.
// ----------------------------------------------------------------------------
module pice_alu (
    input  pice_pkg::instr_t            instr,
    input  pice_pkg::arch_t             arch,
    input  logic                        core_kind,
    input  logic [pice_pkg::PC_W-1:0]   top_data,
    output pice_pkg::arch_t             arch_next,
    output pice_pkg::stack_ctl_t        stack_ctl,
    output pice_pkg::result_t           result
);

    logic [pice_pkg::BYTE_W-1:0] f;
    logic [pice_pkg::BYTE_W-1:0] w;
    logic [pice_pkg::BYTE_W-1:0] bit_mask;
    logic [pice_pkg::BYTE_W:0]   sum9;
    logic [4:0]                  nib_sum;
    logic [pice_pkg::TGT_W-1:0]  call_mask;
    logic [pice_pkg::TGT_W-1:0]  goto_mask;
    logic [pice_pkg::BYTE_W-1:0] res;
    logic                        alu_op;
    logic                        wf;
    logic                        tw;

    assign f        = instr.file_value;
    assign w        = arch.w;
    assign bit_mask = 8'h01 << instr.bit_index;
    assign sum9     = {1'b0, f} + {1'b0, w};
    assign nib_sum  = {1'b0, f[3:0]} + {1'b0, w[3:0]};

    // Branch target masks per core kind
    assign call_mask = (core_kind == pice_pkg::CORE_MIDRANGE) ?
                       pice_pkg::JUMP_MASK_MID : pice_pkg::CALL_MASK_BASE;
    assign goto_mask = (core_kind == pice_pkg::CORE_MIDRANGE) ?
                       pice_pkg::JUMP_MASK_MID : pice_pkg::GOTO_MASK_BASE;

    always_comb begin
        arch_next  = arch;
        res        = '0;
        alu_op     = 1'b0;
        wf         = 1'b0;
        tw         = 1'b0;
        stack_ctl  = '0;
        result     = '0;
        stack_ctl.push_addr = instr.next_address;

        unique case (instr.operation)
            pice_pkg::OP_ADDWF: begin
                res          = sum9[7:0];
                alu_op       = 1'b1;
                arch_next.c  = sum9[8];
                arch_next.dc = nib_sum[4];
                arch_next.z  = (sum9[7:0] == '0);
            end
            pice_pkg::OP_ANDLW: begin
                arch_next.w = w & instr.literal;
                arch_next.z = ((w & instr.literal) == '0);
            end
            pice_pkg::OP_ANDWF: begin
                res         = f & w;
                alu_op      = 1'b1;
                arch_next.z = ((f & w) == '0);
            end
            pice_pkg::OP_BCF: begin
                res = f & ~bit_mask;
                wf  = 1'b1;
            end
            pice_pkg::OP_BSF: begin
                res = f | bit_mask;
                wf  = 1'b1;
            end
            pice_pkg::OP_BTFSC: begin
                if ((f & bit_mask) == '0) begin
                    result.pc_action = pice_pkg::PC_SKIP;
                end
            end
            pice_pkg::OP_BTFSS: begin
                if ((f & bit_mask) != '0) begin
                    result.pc_action = pice_pkg::PC_SKIP;
                end
            end
            pice_pkg::OP_CALL: begin
                stack_ctl.push   = 1'b1;
                result.pc_action = pice_pkg::PC_JUMP;
                result.next_pc   = instr.page_bits |
                                   {2'b00, instr.branch_target & call_mask};
            end
            pice_pkg::OP_CLRF: begin
                wf          = 1'b1;
                arch_next.z = 1'b1;
            end
            pice_pkg::OP_CLRW: begin
                arch_next.w = '0;
                arch_next.z = 1'b1;
            end
            pice_pkg::OP_CLRWDT: begin
                result.clear_watchdog = 1'b1;
            end
            pice_pkg::OP_COMF: begin
                res         = ~f;
                alu_op      = 1'b1;
                arch_next.z = (f == 8'hff);
            end
            pice_pkg::OP_DECF: begin
                res         = f - 8'd1;
                alu_op      = 1'b1;
                arch_next.z = (f == 8'd1);
            end
            pice_pkg::OP_DECFSZ: begin
                res    = f - 8'd1;
                alu_op = 1'b1;
                if (f == 8'd1) begin
                    result.pc_action = pice_pkg::PC_SKIP;
                end
            end
            pice_pkg::OP_GOTO: begin
                result.pc_action = pice_pkg::PC_JUMP;
                result.next_pc   = instr.page_bits |
                                   {2'b00, instr.branch_target & goto_mask};
            end
            pice_pkg::OP_INCF: begin
                res         = f + 8'd1;
                alu_op      = 1'b1;
                arch_next.z = (f == 8'hff);
            end
            pice_pkg::OP_INCFSZ: begin
                res    = f + 8'd1;
                alu_op = 1'b1;
                if (f == 8'hff) begin
                    result.pc_action = pice_pkg::PC_SKIP;
                end
            end
            pice_pkg::OP_IORLW: begin
                arch_next.w = w | instr.literal;
                arch_next.z = ((w | instr.literal) == '0);
            end
            pice_pkg::OP_IORWF: begin
                res         = f | w;
                alu_op      = 1'b1;
                arch_next.z = ((f | w) == '0);
            end
            pice_pkg::OP_MOVLW: begin
                arch_next.w = instr.literal;
            end
            pice_pkg::OP_MOVF: begin
                res         = f;
                alu_op      = 1'b1;
                arch_next.z = (f == '0);
            end
            pice_pkg::OP_MOVWF: begin
                res = w;
                wf  = 1'b1;
            end
            pice_pkg::OP_OPTION: begin
                result.option_write = 1'b1;
            end
            pice_pkg::OP_RETLW: begin
                stack_ctl.pop    = 1'b1;
                arch_next.w      = instr.literal;
                result.pc_action = pice_pkg::PC_JUMP;
                result.next_pc   = top_data;
            end
            pice_pkg::OP_RLF: begin
                res         = {f[6:0], arch.c};
                alu_op      = 1'b1;
                arch_next.c = f[7];
            end
            pice_pkg::OP_RRF: begin
                res         = {arch.c, f[7:1]};
                alu_op      = 1'b1;
                arch_next.c = f[0];
            end
            pice_pkg::OP_SLEEP: begin
                result.pc_action = pice_pkg::PC_SLEEP;
            end
            pice_pkg::OP_SUBWF: begin
                // Carry and digit carry mean no borrow
                res          = f - w;
                alu_op       = 1'b1;
                arch_next.c  = (f >= w);
                arch_next.dc = (f[3:0] >= w[3:0]);
                arch_next.z  = (f == w);
            end
            pice_pkg::OP_SWAPF: begin
                res    = {f[3:0], f[7:4]};
                alu_op = 1'b1;
            end
            pice_pkg::OP_TRIS: begin
                tw = 1'b1;
            end
            pice_pkg::OP_XORLW: begin
                arch_next.w = w ^ instr.literal;
                arch_next.z = (w == instr.literal);
            end
            pice_pkg::OP_XORWF: begin
                res         = f ^ w;
                alu_op      = 1'b1;
                arch_next.z = (f == w);
            end
            default: begin
                // nop and undefined kinds leave everything alone
            end
        endcase

        // Steer ALU result by the destination bit
        if (alu_op) begin
            if (instr.to_file) begin
                wf = 1'b1;
            end else begin
                arch_next.w = res;
            end
        end

        result.write_file       = wf;
        result.result_value     = wf ? res : (tw ? w : '0);
        result.w_value          = arch_next.w;
        result.carry_flag       = arch_next.c;
        result.digit_carry_flag = arch_next.dc;
        result.zero_flag        = arch_next.z;
        result.tris_write       = tw;
    end

endmodule

>>> sv/pic_core_instruction_execute.sv
// Path from input accept to m_tvalid: input register, then result register.
// Throughput: one instruction per cycle unless m_tready holds the result register;
// the W/flag/stack loop closes through the ALU, so only back-pressure stalls it.
// Reset (aresetn low, synchronous): W, C, DC, Z, stack pointer and stack valid
// bits clear, core_kind returns to the mid-range core, both stages empty.
// ----------------------------------------------------------------------------
// PIC core instruction execute unit
// Executes decoded baseline/mid-range PIC instructions against W, the status
// flags and a circular return stack, one stream request per instruction.
// ----------------------------------------------------------------------------
`include "pic_core_instruction_execute_macros.svh"

module pic_core_instruction_execute #(
    parameter int STACK_DEPTH = pice_pkg::STACK_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pice_pkg::ADDR_W-1:0]   paddr,
    input  logic [pice_pkg::DATA_W-1:0]   pwdata,
    output logic [pice_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,

    // Instruction stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [7:0] file_value, [15:8] literal, [16] to_file, [19:17] bit_index,
    // [30:20] branch_target, [43:31] next_address, [56:44] page_bits, [63:57] zero
    input  logic [63:0]                   s_tdata,
    // [5:0] operation
    input  logic [5:0]                    s_tuser,

    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] write_file, [8:1] result_value, [16:9] w_value, [17] carry_flag,
    // [18] digit_carry_flag, [19] zero_flag, [21:20] pc_action, [34:22] next_pc,
    // [35] clear_watchdog, [36] option_write, [37] tris_write, [39:38] zero
    output logic [39:0]                   m_tdata
);

    logic                       core_kind_reg;
    logic                       cfg_write;

    pice_pkg::instr_t           instr_reg;
    pice_pkg::instr_t           instr_next;
    logic                       in_valid_reg;
    logic                       move;

    pice_pkg::arch_t            arch_reg;
    pice_pkg::arch_t            arch_next;
    pice_pkg::stack_ctl_t       alu_stack_ctl;
    pice_pkg::stack_ctl_t       stack_ctl;
    logic [pice_pkg::PC_W-1:0]  top_data;

    pice_pkg::result_t          alu_result;
    pice_pkg::result_t          result_reg;
    logic                       out_valid_reg;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2:2] == pice_pkg::REG_CORE_KIND) ?
                       {{(pice_pkg::DATA_W-1){1'b0}}, core_kind_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            core_kind_reg <= pice_pkg::CORE_MIDRANGE;
        end else if (cfg_write && (paddr[2:2] == pice_pkg::REG_CORE_KIND)) begin
            core_kind_reg <= pwdata[0];
        end
    end

    // Advance the input stage into the result register
    assign move     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || move;

    // Unpack the incoming request
    always_comb begin
        instr_next.operation     = s_tuser;
        instr_next.file_value    = s_tdata[7:0];
        instr_next.literal       = s_tdata[15:8];
        instr_next.to_file       = s_tdata[16];
        instr_next.bit_index     = s_tdata[19:17];
        instr_next.branch_target = s_tdata[30:20];
        instr_next.next_address  = s_tdata[43:31];
        instr_next.page_bits     = s_tdata[56:44];
    end

    // Input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            instr_reg <= instr_next;
        end
    end

    // Execute
    pice_alu u_alu (
        .instr     (instr_reg),
        .arch      (arch_reg),
        .core_kind (core_kind_reg),
        .top_data  (top_data),
        .arch_next (arch_next),
        .stack_ctl (alu_stack_ctl),
        .result    (alu_result)
    );

    // Gate stack requests with the stage advance
    always_comb begin
        stack_ctl           = alu_stack_ctl;
        stack_ctl.push      = alu_stack_ctl.push && move;
        stack_ctl.pop       = alu_stack_ctl.pop && move;
    end

    pice_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (stack_ctl),
        .top_data (top_data)
    );

    // W and flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arch_reg <= '0;
        end else if (move) begin
            arch_reg <= arch_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (move) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            result_reg <= alu_result;
        end
    end

    // Pack the result request
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       result_reg.tris_write,
                       result_reg.option_write,
                       result_reg.clear_watchdog,
                       result_reg.next_pc,
                       result_reg.pc_action,
                       result_reg.zero_flag,
                       result_reg.digit_carry_flag,
                       result_reg.carry_flag,
                       result_reg.w_value,
                       result_reg.result_value,
                       result_reg.write_file};

    // Checks
    `PICE_ASSERT_IMPLY(a_npc_only_on_jump, aclk, aresetn, m_tvalid && (result_reg.pc_action != pice_pkg::PC_JUMP), result_reg.next_pc == '0)
    `PICE_ASSERT_IMPLY(a_tris_carries_w, aclk, aresetn, m_tvalid && result_reg.tris_write, !result_reg.write_file && (result_reg.result_value == result_reg.w_value))
    `PICE_ASSERT_NEXT(a_state_held_on_stall, aclk, aresetn, out_valid_reg && !m_tready, $stable(arch_reg))

endmodule
